@@ rtl/dbt_pkg.sv @@
// dbt_pkg: shared types, constants and the line-rate table of the
// dma line bandwidth tracker; no dependencies
package dbt_pkg;

   // field widths
   localparam int CplWidth    = 10;
   localparam int KindWidth   = 2;
   localparam int LenWidth    = 16;
   localparam int LineWidth   = 9;
   localparam int RemWidth    = 17;
   localparam int RateWidth   = 8;
   localparam int SelWidth    = 2;

   // serial divider: (cpl << 16) / rate, two quotient bits per cycle
   localparam int FracBits    = 16;
   localparam int DivWidth    = CplWidth + FracBits;
   localparam int DivCycles   = DivWidth / 2;
   localparam int DivCntWidth = $clog2(DivCycles + 1);
   // rate is never below 8, so the quotient fits in 23 bits
   localparam int QuotWidth   = DivWidth - 3;

   // serial multiplier: quotient * remainder, two multiplier bits per cycle
   localparam int MulCycles   = RateWidth / 2;
   localparam int MulCntWidth = $clog2(MulCycles + 1);
   localparam int AccWidth    = QuotWidth + RateWidth;

   // zero length on start stands for a full 64k transfer
   localparam logic [RemWidth-1:0] FullLength = 17'h10000;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_CPU_CYCLES_PER_LINE = 1'b0,
      CSR_IGNORE_ZERO_LENGTH  = 1'b1
   } csr_index_type;

   // transfer kinds
   typedef enum logic [KindWidth-1:0] {
      KIND_MEM_VRAM = 2'd0,
      KIND_MEM_CRAM = 2'd1,
      KIND_FILL     = 2'd2,
      KIND_COPY     = 2'd3
   } kind_type;

   // commands
   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   // control sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHARGE = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_MUL    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   // words per line, indexed by kind and {wide, blank}
   typedef logic [RateWidth-1:0] rate_row_type [4];
   localparam rate_row_type LineRate [4] = '{
      '{8'd8,  8'd83,  8'd9,  8'd102},
      '{8'd16, 8'd167, 8'd18, 8'd205},
      '{8'd15, 8'd166, 8'd17, 8'd204},
      '{8'd8,  8'd83,  8'd9,  8'd102}
   };

   function automatic logic [RateWidth-1:0] line_rate(
      input logic [KindWidth-1:0] kind,
      input logic [SelWidth-1:0]  sel
   );
      return LineRate[kind][sel];
   endfunction

endpackage

@@ rtl/dbt_ifs.sv @@
// dbt_ifs: valid/ready channel interfaces for request, response and csr writes
// depends on dbt_pkg

interface dbt_req_if;
   import dbt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [KindWidth-1:0] dma_kind;
   logic [LenWidth-1:0]  length_words;
   logic                 wide_mode;
   logic                 display_enabled;
   logic [LineWidth-1:0] current_line;
   logic [LineWidth-1:0] visible_lines;

   modport source (output valid, cmd, dma_kind, length_words, wide_mode,
                   display_enabled, current_line, visible_lines, input ready);
   modport sink   (input valid, cmd, dma_kind, length_words, wide_mode,
                   display_enabled, current_line, visible_lines, output ready);
endinterface

interface dbt_rsp_if;
   import dbt_pkg::*;
   logic                valid;
   logic                ready;
   logic [CplWidth-1:0] stolen_cycles;
   logic                busy_res;
   logic [RemWidth-1:0] remaining;

   modport source (output valid, stolen_cycles, busy_res, remaining, input ready);
   modport sink   (input valid, stolen_cycles, busy_res, remaining, output ready);
endinterface

interface dbt_csr_if;
   import dbt_pkg::*;
   logic                valid;
   logic                ready;
   logic [0:0]          index;
   logic [CplWidth-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/dbt_div.sv @@
// dbt_div: radix-4 restoring divider, (cpl << 16) / rate, two bits per cycle
// depends on dbt_pkg
module dbt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dbt_pkg::CplWidth-1:0]  cpl,
   input  logic [dbt_pkg::RateWidth-1:0] rate,
   output logic                          done,
   output logic [dbt_pkg::QuotWidth-1:0] quotient
);
   import dbt_pkg::*;

   logic [DivWidth-1:0]    work_ff, work_in;
   logic [RateWidth-1:0]   rem_ff, rem_in;
   logic [RateWidth-1:0]   rate_ff, rate_in;
   logic [DivCntWidth-1:0] cnt_ff, cnt_in;
   logic                   done_ff, done_in;

   logic [RateWidth:0]     t1, t2;
   logic [RateWidth-1:0]   r1;
   logic                   q1, q2;

   // two dependent restoring steps on the narrow partial remainder
   always_comb begin
      t1 = {rem_ff, work_ff[DivWidth-1]};
      q1 = (t1 >= {1'b0, rate_ff});
      r1 = q1 ? RateWidth'(t1 - {1'b0, rate_ff}) : t1[RateWidth-1:0];
      t2 = {r1, work_ff[DivWidth-2]};
      q2 = (t2 >= {1'b0, rate_ff});
   end

   // dividend shifts out the top while quotient bits shift in at the bottom
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      rate_in = rate_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = {cpl, {FracBits{1'b0}}};
         rem_in  = '0;
         rate_in = rate;
         cnt_in  = DivCntWidth'(DivCycles);
      end else if (cnt_ff != '0) begin
         work_in = {work_ff[DivWidth-3:0], q1, q2};
         rem_in  = q2 ? RateWidth'(t2 - {1'b0, rate_ff}) : t2[RateWidth-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DivCntWidth'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      rate_ff <= rate_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff[QuotWidth-1:0];

endmodule

@@ rtl/dbt_mul.sv @@
// dbt_mul: radix-4 shift-add multiplier, msb-first over the 8-bit remainder
// depends on dbt_pkg
module dbt_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dbt_pkg::QuotWidth-1:0] multiplicand,
   input  logic [dbt_pkg::RateWidth-1:0] multiplier,
   output logic                          done,
   output logic [dbt_pkg::CplWidth-1:0]  product
);
   import dbt_pkg::*;

   logic [QuotWidth-1:0]   mcand_ff, mcand_in;
   logic [RateWidth-1:0]   mplier_ff, mplier_in;
   logic [AccWidth-1:0]    acc_ff, acc_in;
   logic [MulCntWidth-1:0] cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [AccWidth-1:0]    pp_hi, pp_lo;

   // partial products for the current two-bit digit
   always_comb begin
      pp_hi = mplier_ff[RateWidth-1] ? {{(AccWidth-QuotWidth-1){1'b0}}, mcand_ff, 1'b0} : '0;
      pp_lo = mplier_ff[RateWidth-2] ? {{(AccWidth-QuotWidth){1'b0}}, mcand_ff} : '0;
   end

   // horner accumulation, one digit per cycle
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         acc_in    = '0;
         cnt_in    = MulCntWidth'(MulCycles);
      end else if (cnt_ff != '0) begin
         acc_in    = {acc_ff[AccWidth-3:0], 2'b00} + pp_hi + pp_lo;
         mplier_in = {mplier_ff[RateWidth-3:0], 2'b00};
         cnt_in    = cnt_ff - 1'b1;
         done_in   = (cnt_ff == MulCntWidth'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   // product never exceeds cpl, so the integer part fits in 10 bits
   assign done    = done_ff;
   assign product = acc_ff[FracBits+CplWidth-1:FracBits];

endmodule

@@ rtl/dma_line_bandwidth_tracker.sv @@
// dma_line_bandwidth_tracker: per-scanline dma transfer tracker, top level
// a request passes the charge and done states before its response is registered;
// a memory transfer that ends adds a serial divide, then a serial multiply
// one transaction at a time; the next request is taken once its result
// is registered. reset: synchronous active high, cpu_cycles_per_line 488,
// sequencer idle, other control registers zero, datapath registers not reset
module dma_line_bandwidth_tracker (
   input logic  clock,
   input logic  reset,
   dbt_req_if.sink   req_ch,
   dbt_rsp_if.source rsp_ch,
   dbt_csr_if.sink   csr_ch
);
   import dbt_pkg::*;

   state_type            state_ff, state_in;
   logic [CplWidth-1:0]  cpl_ff, cpl_in;
   logic                 izl_ff, izl_in;
   logic [RemWidth-1:0]  rem_units_ff, rem_units_in;
   logic [KindWidth-1:0] kind_ff, kind_in;
   logic                 busy_ff, busy_in;
   logic [SelWidth-1:0]  sel_ff, sel_in;
   logic                 charge_ff, charge_in;
   logic [CplWidth-1:0]  stolen_ff, stolen_in;
   logic [RateWidth-1:0] mrem_ff, mrem_in;
   logic [RateWidth-1:0] rate_ff, rate_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CplWidth-1:0]  rsp_stolen_ff, rsp_stolen_in;
   logic                 rsp_busy_ff, rsp_busy_in;
   logic [RemWidth-1:0]  rsp_rem_ff, rsp_rem_in;

   logic                 req_fire;
   logic                 ignore_start;
   logic                 blank;
   logic [RateWidth-1:0] rate;
   logic                 div_start, div_done;
   logic [QuotWidth-1:0] quotient;
   logic                 mul_start, mul_done;
   logic [CplWidth-1:0]  product;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // request decode
   always_comb begin
      ignore_start = (req_ch.length_words == '0) && izl_ff &&
                     (req_ch.dma_kind != KIND_FILL);
      blank        = (req_ch.current_line >= req_ch.visible_lines) ||
                     !req_ch.display_enabled;
      rate         = line_rate(kind_ff, sel_ff);
   end

   // configuration writes
   always_comb begin
      cpl_in = cpl_ff;
      izl_in = izl_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_CPU_CYCLES_PER_LINE: cpl_in = csr_ch.data;
            CSR_IGNORE_ZERO_LENGTH:  izl_in = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // control sequencer
   always_comb begin
      state_in     = state_ff;
      rem_units_in = rem_units_ff;
      kind_in      = kind_ff;
      busy_in      = busy_ff;
      sel_in       = sel_ff;
      charge_in    = charge_ff;
      stolen_in    = stolen_ff;
      mrem_in      = mrem_ff;
      rate_in      = rate_ff;
      div_start    = 1'b0;
      mul_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sel_in   = {req_ch.wide_mode, blank};
               state_in = ST_CHARGE;
               if (req_ch.cmd == CMD_TICK) begin
                  charge_in = 1'b1;
               end else if (ignore_start) begin
                  charge_in = 1'b0;
               end else begin
                  kind_in      = req_ch.dma_kind;
                  rem_units_in = (req_ch.length_words == '0) ? FullLength :
                                 {1'b0, req_ch.length_words};
                  busy_in      = 1'b1;
                  charge_in    = !req_ch.dma_kind[1];
               end
            end
         end
         ST_CHARGE: begin
            stolen_in = '0;
            state_in  = ST_DONE;
            if (charge_ff) begin
               if (rem_units_ff > RemWidth'(rate)) begin
                  // full line moved, transfer continues
                  rem_units_in = rem_units_ff - RemWidth'(rate);
                  stolen_in    = kind_ff[1] ? '0 : cpl_ff;
               end else begin
                  // last partial line ends the transfer
                  rem_units_in = '0;
                  busy_in      = 1'b0;
                  if (!kind_ff[1] && (rem_units_ff != '0)) begin
                     mrem_in   = rem_units_ff[RateWidth-1:0];
                     rate_in   = rate;
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               stolen_in = product;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_stolen_in = rsp_stolen_ff;
      rsp_busy_in   = rsp_busy_ff;
      rsp_rem_in    = rsp_rem_ff;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_stolen_in = stolen_ff;
         rsp_busy_in   = busy_ff;
         rsp_rem_in    = rem_units_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cpl_ff       <= CplWidth'(488);
         izl_ff       <= 1'b0;
         rem_units_ff <= '0;
         kind_ff      <= '0;
         busy_ff      <= 1'b0;
         charge_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cpl_ff       <= cpl_in;
         izl_ff       <= izl_in;
         rem_units_ff <= rem_units_in;
         kind_ff      <= kind_in;
         busy_ff      <= busy_in;
         charge_ff    <= charge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff        <= sel_in;
      stolen_ff     <= stolen_in;
      mrem_ff       <= mrem_in;
      rate_ff       <= rate_in;
      rsp_stolen_ff <= rsp_stolen_in;
      rsp_busy_ff   <= rsp_busy_in;
      rsp_rem_ff    <= rsp_rem_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.stolen_cycles = rsp_stolen_ff;
   assign rsp_ch.busy_res      = rsp_busy_ff;
   assign rsp_ch.remaining     = rsp_rem_ff;

   // partial-line charge: ((cpl << 16) / rate * left) >> 16
   dbt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .cpl      (cpl_ff),
      .rate     (rate),
      .done     (div_done),
      .quotient (quotient)
   );

   dbt_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (quotient),
      .multiplier   (mrem_ff),
      .done         (mul_done),
      .product      (product)
   );

   // assertions
   a_idle_no_remaining: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> rem_units_ff == '0)
      else $error("idle tracker holds outstanding units");

   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      rem_units_ff <= FullLength)
      else $error("remaining units exceed a full transfer");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide phase");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL)
      else $error("multiplier finished outside the multiply phase");

   a_partial_rate: assert property (@(posedge clock) disable iff (reset)
      div_start |=> mrem_ff <= rate_ff && rate_ff != '0)
      else $error("partial line exceeds the line rate");

endmodule
